// ===== rtl/mwr_pkg.sv =====
`default_nettype none

package mwr_pkg;

  localparam int DIM_W  = 13;
  localparam int MODE_W = 4;
  localparam int IDX_W  = 6;
  localparam int SIDE_W = 4;
  localparam int CNT_W  = 7;
  localparam int K_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WINDOWS = 64;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOWS);

  localparam logic [DIM_W-1:0]  SCREEN_WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0]  SCREEN_HEIGHT_RST = 13'd1080;
  localparam logic [MODE_W-1:0] LAYOUT_MODE_RST   = 4'd0;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_G1   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_G4   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_G9   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_G16  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BIG5 = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BIG7 = 4'd5;
  localparam logic [MODE_W-1:0] MODE_PAIR = 4'd6;
  localparam logic [MODE_W-1:0] MODE_G25  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_G36  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_G49  = 4'd9;
  localparam logic [MODE_W-1:0] MODE_G64  = 4'd10;

  // decode: side, divider estimates, grid row
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  sw;
    logic [DIM_W-1:0]  sh;
    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] side_h;
    logic [CNT_W-1:0]  count;
    logic              hit;
    logic [DIM_W-1:0]  qw0;
    logic [DIM_W-1:0]  qh0;
    logic [IDX_W-1:0]  row;
  } s1_t;

  // cell size and per-window cell factors
  typedef struct packed {
    logic [DIM_W-1:0]  sw;
    logic [DIM_W-1:0]  sh;
    logic [DIM_W-1:0]  cw;
    logic [DIM_W-1:0]  ch;
    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] ko;
    logic [K_W-1:0]    kx;
    logic [K_W-1:0]    ky;
    logic [K_W-1:0]    kw;
    logic [K_W-1:0]    kh;
    logic              hit;
  } s2_t;

  // scaled products
  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] cws;
    logic [DIM_W-1:0] chs;
    logic [DIM_W-1:0] px;
    logic [DIM_W-1:0] py;
    logic [DIM_W-1:0] pw;
    logic [DIM_W-1:0] ph;
    logic             hit;
  } s3_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             in_layout;
  } rect_t;

  function automatic logic [SIDE_W-1:0] grid_side(input logic [MODE_W-1:0] mode);
    logic [SIDE_W-1:0] s;
    unique case (mode)
      MODE_G1:   s = 4'd1;
      MODE_G4:   s = 4'd2;
      MODE_G9:   s = 4'd3;
      MODE_G16:  s = 4'd4;
      MODE_BIG5: s = 4'd3;
      MODE_BIG7: s = 4'd4;
      MODE_PAIR: s = 4'd2;
      MODE_G25:  s = 4'd5;
      MODE_G36:  s = 4'd6;
      MODE_G49:  s = 4'd7;
      MODE_G64:  s = 4'd8;
      default:   s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [CNT_W-1:0] win_count(input logic [MODE_W-1:0] mode);
    logic [CNT_W-1:0] c;
    unique case (mode)
      MODE_G1:   c = 7'd1;
      MODE_G4:   c = 7'd4;
      MODE_G9:   c = 7'd9;
      MODE_G16:  c = 7'd16;
      MODE_BIG5: c = 7'd6;
      MODE_BIG7: c = 7'd8;
      MODE_PAIR: c = 7'd2;
      MODE_G25:  c = 7'd25;
      MODE_G36:  c = 7'd36;
      MODE_G49:  c = 7'd49;
      MODE_G64:  c = 7'd64;
      default:   c = 7'd0;
    endcase
    return c;
  endfunction

  // floor(2^16 / side): estimate is exact or one short for 13-bit dividends
  function automatic logic [16:0] recip16(input logic [SIDE_W-1:0] side);
    logic [16:0] r;
    unique case (side)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13107;
      4'd6:    r = 17'd10922;
      4'd7:    r = 17'd9362;
      4'd8:    r = 17'd8192;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // ceil(2^9 / side): exact quotient for 6-bit dividends
  function automatic logic [9:0] recip9(input logic [SIDE_W-1:0] side);
    logic [9:0] r;
    unique case (side)
      4'd1:    r = 10'd512;
      4'd2:    r = 10'd256;
      4'd3:    r = 10'd171;
      4'd4:    r = 10'd128;
      4'd5:    r = 10'd103;
      4'd6:    r = 10'd86;
      4'd7:    r = 10'd74;
      4'd8:    r = 10'd64;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mwr_if.sv =====
`default_nettype none

interface mwr_in_if;
  logic                     valid;
  logic                     ready;
  logic [mwr_pkg::IDX_W-1:0] window_index;

  modport source (output valid, output window_index, input ready);
  modport sink   (input valid, input window_index, output ready);
endinterface

interface mwr_out_if;
  logic                     valid;
  logic                     ready;
  logic [mwr_pkg::DIM_W-1:0] rect_x;
  logic [mwr_pkg::DIM_W-1:0] rect_y;
  logic [mwr_pkg::DIM_W-1:0] rect_width;
  logic [mwr_pkg::DIM_W-1:0] rect_height;
  logic                     in_layout;

  modport source (output valid, output rect_x, output rect_y, output rect_width,
                  output rect_height, output in_layout, input ready);
  modport sink   (input valid, input rect_x, input rect_y, input rect_width,
                  input rect_height, input in_layout, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwr_decode.sv =====
`default_nettype none

module mwr_decode (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      v_in,
  input  wire logic [mwr_pkg::IDX_W-1:0]  idx,
  input  wire logic [mwr_pkg::MODE_W-1:0] mode,
  input  wire logic [mwr_pkg::DIM_W-1:0]  sw,
  input  wire logic [mwr_pkg::DIM_W-1:0]  sh,
  output logic                           v_r,
  output mwr_pkg::s1_t                   s1_r
);
  import mwr_pkg::*;

  s1_t              s1_nxt;
  logic [CNT_W-1:0] wc;
  logic [29:0]      pw;
  logic [29:0]      ph;
  logic [15:0]      pr;

  always_comb begin
    s1_nxt.idx    = idx;
    s1_nxt.mode   = mode;
    s1_nxt.sw     = sw;
    s1_nxt.sh     = sh;
    s1_nxt.side   = grid_side(mode);
    s1_nxt.side_h = (mode == MODE_PAIR) ? 4'd2 : s1_nxt.side;
    wc            = win_count(mode);
    s1_nxt.count  = (wc > CNT_MAX) ? CNT_MAX : wc;
    s1_nxt.hit    = (s1_nxt.side != '0) && ({1'b0, idx} < s1_nxt.count);
    pw            = 30'(sw) * 30'(recip16(s1_nxt.side));
    ph            = 30'(sh) * 30'(recip16(s1_nxt.side_h));
    pr            = 16'(idx) * 16'(recip9(s1_nxt.side));
    s1_nxt.qw0    = pw[28:16];
    s1_nxt.qh0    = ph[28:16];
    s1_nxt.row    = pr[14:9];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mwr_divfix.sv =====
`default_nettype none

module mwr_divfix (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         v_in,
  input  wire mwr_pkg::s1_t s1,
  output logic              v_r,
  output mwr_pkg::s2_t      s2_r
);
  import mwr_pkg::*;

  s2_t              s2_nxt;
  logic [16:0]      qsw;
  logic [16:0]      qsh;
  logic [DIM_W-1:0] rw;
  logic [DIM_W-1:0] rh;
  logic [DIM_W-1:0] qw;
  logic [DIM_W-1:0] qh;
  logic [9:0]       rs;
  logic [IDX_W-1:0] col;
  logic [CNT_W-1:0] first_bottom;
  logic [IDX_W-1:0] kb;
  logic [SIDE_W-1:0] sm1;

  always_comb begin
    // one-step correction of the reciprocal estimates
    qsw = 17'(s1.qw0) * 17'(s1.side);
    qsh = 17'(s1.qh0) * 17'(s1.side_h);
    rw  = s1.sw - qsw[DIM_W-1:0];
    rh  = s1.sh - qsh[DIM_W-1:0];
    qw  = s1.qw0 + DIM_W'(rw >= DIM_W'(s1.side));
    qh  = s1.qh0 + DIM_W'(rh >= DIM_W'(s1.side_h));

    rs  = 10'(s1.row) * 10'(s1.side);
    col = s1.idx - rs[IDX_W-1:0];
    sm1 = s1.side - 4'd1;
    first_bottom = s1.count - CNT_W'(s1.side);
    kb  = s1.idx + IDX_W'(s1.side) - s1.count[IDX_W-1:0];

    s2_nxt.sw   = s1.sw;
    s2_nxt.sh   = s1.sh;
    s2_nxt.cw   = {qw[DIM_W-1:4], 4'b0};
    s2_nxt.ch   = {qh[DIM_W-1:1], 1'b0};
    s2_nxt.side = s1.side;
    s2_nxt.ko   = (s1.mode == MODE_PAIR) ? 4'd1 : s1.side;
    s2_nxt.hit  = s1.hit;
    s2_nxt.kw   = 3'd1;
    s2_nxt.kh   = 3'd1;

    priority if (s1.mode == MODE_PAIR) begin
      s2_nxt.kx = s1.idx[K_W-1:0];
      s2_nxt.ky = '0;
    end else if (s1.mode == MODE_BIG5 || s1.mode == MODE_BIG7) begin
      priority if (s1.idx == '0) begin
        s2_nxt.kx = '0;
        s2_nxt.ky = '0;
        s2_nxt.kw = sm1[K_W-1:0];
        s2_nxt.kh = sm1[K_W-1:0];
      end else if ({1'b0, s1.idx} >= first_bottom) begin
        s2_nxt.kx = kb[K_W-1:0];
        s2_nxt.ky = sm1[K_W-1:0];
      end else begin
        s2_nxt.kx = sm1[K_W-1:0];
        s2_nxt.ky = K_W'(s1.idx - 6'd1);
      end
    end else begin
      s2_nxt.kx = col[K_W-1:0];
      s2_nxt.ky = s1.row[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mwr_scale.sv =====
`default_nettype none

module mwr_scale (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         v_in,
  input  wire mwr_pkg::s2_t s2,
  output logic              v_r,
  output mwr_pkg::s3_t      s3_r
);
  import mwr_pkg::*;

  s3_t         s3_nxt;
  logic [16:0] cws;
  logic [16:0] chs;
  logic [15:0] px;
  logic [15:0] py;
  logic [15:0] pw;
  logic [15:0] ph;

  always_comb begin
    cws = 17'(s2.cw) * 17'(s2.side);
    chs = 17'(s2.ch) * 17'(s2.ko);
    px  = 16'(s2.cw) * 16'(s2.kx);
    py  = 16'(s2.ch) * 16'(s2.ky);
    pw  = 16'(s2.cw) * 16'(s2.kw);
    ph  = 16'(s2.ch) * 16'(s2.kh);
    s3_nxt.sw  = s2.sw;
    s3_nxt.sh  = s2.sh;
    s3_nxt.cws = cws[DIM_W-1:0];
    s3_nxt.chs = chs[DIM_W-1:0];
    s3_nxt.px  = px[DIM_W-1:0];
    s3_nxt.py  = py[DIM_W-1:0];
    s3_nxt.pw  = pw[DIM_W-1:0];
    s3_nxt.ph  = ph[DIM_W-1:0];
    s3_nxt.hit = s2.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mwr_place.sv =====
`default_nettype none

module mwr_place (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         v_in,
  input  wire mwr_pkg::s3_t s3,
  output logic              v_r,
  output mwr_pkg::rect_t    rect_r
);
  import mwr_pkg::*;

  rect_t            rect_nxt;
  logic [DIM_W-1:0] xd;
  logic [DIM_W-1:0] yd;
  logic [DIM_W-1:0] xo;
  logic [DIM_W-1:0] yo;

  always_comb begin
    // centring margin halved, then aligned down to 2
    xd = s3.sw - s3.cws;
    yd = s3.sh - s3.chs;
    xo = {1'b0, xd[DIM_W-1:2], 1'b0};
    yo = {1'b0, yd[DIM_W-1:2], 1'b0};
    if (s3.hit) begin
      rect_nxt.x = s3.px + xo;
      rect_nxt.y = s3.py + yo;
      rect_nxt.w = s3.pw;
      rect_nxt.h = s3.ph;
    end else begin
      rect_nxt.x = '0;
      rect_nxt.y = '0;
      rect_nxt.w = '0;
      rect_nxt.h = '0;
    end
    rect_nxt.in_layout = s3.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rect_r <= rect_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mosaic_window_rect.sv =====
// Mosaic window placement: for each window index word on in_win the block
// returns the screen rectangle of that window (x, y, width, height) and an
// in_layout flag for the layout held in the configuration registers. One
// index is taken every clock cycle unless a stall on out_rect backs up to
// the input, and its result passes through four register stages: decode with
// reciprocal divide estimates, quotient correction and cell factors, cell
// scaling products, and centring plus the output register. Each stage holds
// its word only while the stage after it is full and stalled, so bubbles are
// squeezed out and the input keeps taking words while a finished result waits
// on out_rect. Indices outside the layout return zeros with in_layout low.
// Write the configuration registers only while no word is in flight.
`default_nettype none

module mosaic_window_rect (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [mwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mwr_pkg::DIM_W-1:0]     cfg_wdata,
  mwr_in_if.sink                            in_win,
  mwr_out_if.source                         out_rect
);
  import mwr_pkg::*;

  logic [DIM_W-1:0]  screen_width_r;
  logic [DIM_W-1:0]  screen_height_r;
  logic [MODE_W-1:0] layout_mode_r;

  logic  v1_r, v2_r, v3_r, v4_r;
  logic  en1, en2, en3, en4;
  s1_t   s1_r;
  s2_t   s2_r;
  s3_t   s3_r;
  rect_t rect_r;

  // configuration registers; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      layout_mode_r   <= LAYOUT_MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        REG_LAYOUT_MODE:   layout_mode_r   <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its word moves on this cycle
  assign en4 = !v4_r || out_rect.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_win.ready = en1;

  mwr_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en1),
    .v_in  (in_win.valid),
    .idx   (in_win.window_index),
    .mode  (layout_mode_r),
    .sw    (screen_width_r),
    .sh    (screen_height_r),
    .v_r   (v1_r),
    .s1_r  (s1_r)
  );

  mwr_divfix u_divfix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en2),
    .v_in  (v1_r),
    .s1    (s1_r),
    .v_r   (v2_r),
    .s2_r  (s2_r)
  );

  mwr_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en3),
    .v_in  (v2_r),
    .s2    (s2_r),
    .v_r   (v3_r),
    .s3_r  (s3_r)
  );

  mwr_place u_place (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en4),
    .v_in   (v3_r),
    .s3     (s3_r),
    .v_r    (v4_r),
    .rect_r (rect_r)
  );

  // drive the result word straight from the output register
  assign out_rect.valid       = v4_r;
  assign out_rect.rect_x      = rect_r.x;
  assign out_rect.rect_y      = rect_r.y;
  assign out_rect.rect_width  = rect_r.w;
  assign out_rect.rect_height = rect_r.h;
  assign out_rect.in_layout   = rect_r.in_layout;

endmodule

`default_nettype wire
